>>> hw/rtl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants for the bounded positional list.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam int CFG_W       = 5;
    localparam int CMD_W       = 4;
    localparam int IO_VALUE_W  = 32;
    localparam int SIZE_W      = 16;
    localparam int POS_W       = 4;
    localparam int STATUS_W    = 3;
    localparam int IO_COUNT_W  = 5;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FIRST = 4'd0,
        CMD_INS_LAST  = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_EXT_FIRST = 4'd3,
        CMD_EXT_LAST  = 4'd4,
        CMD_EXT_AT    = 4'd5,
        CMD_RD_FIRST  = 4'd6,
        CMD_RD_LAST   = 4'd7,
        CMD_RD_AT     = 4'd8,
        CMD_CLEAR     = 4'd9
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 3'd0,
        STS_ZERO  = 3'd1,
        STS_FULL  = 3'd2,
        STS_EMPTY = 3'd3,
        STS_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INS,
        OP_EXT,
        OP_RD,
        OP_CLR
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_WR,
        ST_PUT,
        ST_TAKE_RD,
        ST_TAKE_CAP,
        ST_DN_RD,
        ST_DN_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                    is_empty;
        logic                    is_full;
        logic [IO_COUNT_W-1:0]   count_now;
        logic [SIZE_W-1:0]       out_size;
        logic [IO_VALUE_W-1:0]   out_value;
        status_t                 status;
    } result_t;

endpackage

>>> hw/rtl/bpl_store.sv
// ----------------------------------------------------------------------------
// bpl_store
// Entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bpl_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bpl_seq.sv
// ----------------------------------------------------------------------------
// bpl_seq
// Command sequencer: decodes a command, checks it, and moves entries through
// the entry memory one at a time with a shared pointer unit.
// ----------------------------------------------------------------------------
module bpl_seq #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [bpl_pkg::CMD_W-1:0]     cmd,
    input  logic [bpl_pkg::IO_VALUE_W-1:0] item_value,
    input  logic [bpl_pkg::SIZE_W-1:0]    item_size,
    input  logic [bpl_pkg::POS_W-1:0]     position,
    // capacity register
    input  logic                          cfg_valid,
    input  logic [bpl_pkg::CFG_W-1:0]     cfg_data,
    // result side
    input  logic                          out_free,
    output logic                          res_load,
    output bpl_pkg::result_t              res
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int XW      = (CW > 5) ? CW : 5;
    localparam int EW      = VALUE_WIDTH + bpl_pkg::SIZE_W;
    localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

    bpl_pkg::state_t  state_reg, state_next;
    bpl_pkg::op_t     op_reg;
    bpl_pkg::status_t status_reg;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          cap_reg;
    logic [CW-1:0]          ptr_reg;
    logic [CW-1:0]          idx_reg;
    logic [EW-1:0]          item_reg;
    logic [EW-1:0]          out_reg;

    // decode
    bpl_pkg::op_t     dec_op;
    bpl_pkg::status_t dec_status;
    logic [CW-1:0]    dec_idx;
    logic [XW-1:0]    pos_ext;
    logic [XW-1:0]    cnt_ext;
    logic [XW-1:0]    cfg_ext;
    logic [XW-1:0]    depth_ext;
    logic [XW-1:0]    cap_new;
    logic [63:0]      val_ext;
    logic             accept;

    // shared pointer unit
    logic [CW-1:0]    ptr_dec;
    logic [CW-1:0]    ptr_inc;
    logic [CW-1:0]    ptr_inc2;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [EW-1:0]    mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [EW-1:0]    mem_rdata;

    // finish values
    logic [CW-1:0]    count_fin;
    logic [63:0]      ov_ext;
    logic [15:0]      cnt_fin_ext;

    assign accept    = cmd_valid && cmd_ready;
    assign pos_ext   = XW'(position);
    assign cnt_ext   = XW'(count_reg);
    assign cfg_ext   = XW'(cfg_data);
    assign depth_ext = XW'(DEPTH);
    assign cap_new   = (cfg_ext > depth_ext) ? depth_ext : cfg_ext;
    assign val_ext   = 64'(item_value);

    assign ptr_dec  = ptr_reg - CW'(1);
    assign ptr_inc  = ptr_reg + CW'(1);
    assign ptr_inc2 = ptr_reg + CW'(2);

    always_comb begin
        dec_op     = bpl_pkg::OP_NONE;
        dec_status = bpl_pkg::STS_OK;
        dec_idx    = '0;
        unique case (bpl_pkg::cmd_t'(cmd))
            bpl_pkg::CMD_INS_FIRST, bpl_pkg::CMD_INS_LAST, bpl_pkg::CMD_INS_AT: begin
                dec_op = bpl_pkg::OP_INS;
                if (item_size == '0) begin
                    dec_status = bpl_pkg::STS_ZERO;
                end else if (count_reg >= cap_reg) begin
                    dec_status = bpl_pkg::STS_FULL;
                end
                if (bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_INS_FIRST) begin
                    dec_idx = '0;
                end else if (bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_INS_LAST) begin
                    dec_idx = count_reg;
                end else begin
                    // a position at or past the end appends
                    dec_idx = (pos_ext >= cnt_ext) ? count_reg : pos_ext[CW-1:0];
                end
            end
            bpl_pkg::CMD_EXT_FIRST, bpl_pkg::CMD_EXT_LAST, bpl_pkg::CMD_EXT_AT,
            bpl_pkg::CMD_RD_FIRST, bpl_pkg::CMD_RD_LAST, bpl_pkg::CMD_RD_AT: begin
                if (bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_FIRST ||
                    bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_LAST ||
                    bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_AT) begin
                    dec_op = bpl_pkg::OP_EXT;
                end else begin
                    dec_op = bpl_pkg::OP_RD;
                end
                if (bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_FIRST ||
                    bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_RD_FIRST) begin
                    dec_idx = '0;
                end else if (bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_LAST ||
                             bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_RD_LAST) begin
                    dec_idx = count_reg - CW'(1);
                end else begin
                    dec_idx = pos_ext[CW-1:0];
                end
                if (count_reg == '0) begin
                    dec_status = bpl_pkg::STS_EMPTY;
                end else if ((bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_EXT_AT ||
                              bpl_pkg::cmd_t'(cmd) == bpl_pkg::CMD_RD_AT) &&
                             pos_ext >= cnt_ext) begin
                    dec_status = bpl_pkg::STS_RANGE;
                end
            end
            bpl_pkg::CMD_CLEAR: begin
                dec_op = bpl_pkg::OP_CLR;
            end
            default: begin
                dec_op = bpl_pkg::OP_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bpl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (dec_status != bpl_pkg::STS_OK ||
                        dec_op == bpl_pkg::OP_NONE || dec_op == bpl_pkg::OP_CLR) begin
                        state_next = bpl_pkg::ST_FINISH;
                    end else if (dec_op == bpl_pkg::OP_INS) begin
                        state_next = (count_reg > dec_idx) ? bpl_pkg::ST_UP_RD
                                                           : bpl_pkg::ST_PUT;
                    end else begin
                        state_next = bpl_pkg::ST_TAKE_RD;
                    end
                end
            end
            bpl_pkg::ST_UP_RD:   state_next = bpl_pkg::ST_UP_WR;
            bpl_pkg::ST_UP_WR: begin
                state_next = (ptr_dec != idx_reg) ? bpl_pkg::ST_UP_RD : bpl_pkg::ST_PUT;
            end
            bpl_pkg::ST_PUT:     state_next = bpl_pkg::ST_FINISH;
            bpl_pkg::ST_TAKE_RD: state_next = bpl_pkg::ST_TAKE_CAP;
            bpl_pkg::ST_TAKE_CAP: begin
                if (op_reg == bpl_pkg::OP_EXT && (idx_reg + CW'(1)) < count_reg) begin
                    state_next = bpl_pkg::ST_DN_RD;
                end else begin
                    state_next = bpl_pkg::ST_FINISH;
                end
            end
            bpl_pkg::ST_DN_RD:   state_next = bpl_pkg::ST_DN_WR;
            bpl_pkg::ST_DN_WR: begin
                state_next = (ptr_inc2 < count_reg) ? bpl_pkg::ST_DN_RD
                                                    : bpl_pkg::ST_FINISH;
            end
            bpl_pkg::ST_FINISH:  state_next = bpl_pkg::ST_IDLE;
            default:             state_next = bpl_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        cmd_ready = 1'b0;
        res_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            bpl_pkg::ST_IDLE:     cmd_ready = out_free;
            bpl_pkg::ST_UP_RD:    mem_raddr = ptr_dec[AW-1:0];
            bpl_pkg::ST_UP_WR:    mem_we    = 1'b1;
            bpl_pkg::ST_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = item_reg;
            end
            bpl_pkg::ST_TAKE_RD:  mem_raddr = idx_reg[AW-1:0];
            bpl_pkg::ST_TAKE_CAP: mem_raddr = idx_reg[AW-1:0];
            bpl_pkg::ST_DN_RD:    mem_raddr = ptr_inc[AW-1:0];
            bpl_pkg::ST_DN_WR:    mem_we    = 1'b1;
            bpl_pkg::ST_FINISH:   res_load  = 1'b1;
            default:              cmd_ready = 1'b0;
        endcase
    end

    always_comb begin
        count_fin = count_reg;
        if (status_reg == bpl_pkg::STS_OK) begin
            priority case (op_reg)
                bpl_pkg::OP_INS: count_fin = count_reg + CW'(1);
                bpl_pkg::OP_EXT: count_fin = count_reg - CW'(1);
                bpl_pkg::OP_CLR: count_fin = '0;
                default:         count_fin = count_reg;
            endcase
        end
    end

    assign ov_ext      = 64'(out_reg[VALUE_WIDTH-1:0]);
    assign cnt_fin_ext = 16'(count_fin);

    always_comb begin
        res.status    = status_reg;
        res.out_value = ov_ext[bpl_pkg::IO_VALUE_W-1:0];
        res.out_size  = out_reg[EW-1:VALUE_WIDTH];
        res.count_now = cnt_fin_ext[bpl_pkg::IO_COUNT_W-1:0];
        res.is_full   = (count_fin == cap_reg);
        res.is_empty  = (count_fin == '0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpl_pkg::ST_IDLE;
            count_reg <= '0;
            cap_reg   <= CW'(CAP_RST);
        end else begin
            state_reg <= state_next;
            if (state_reg == bpl_pkg::ST_FINISH) begin
                count_reg <= count_fin;
            end
            // capacity write of zero is ignored; a lower capacity drops the tail
            if (cfg_valid && cfg_data != '0) begin
                cap_reg <= cap_new[CW-1:0];
                if (cnt_ext > cap_new) begin
                    count_reg <= cap_new[CW-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= dec_op;
            status_reg <= dec_status;
            idx_reg    <= dec_idx;
            ptr_reg    <= count_reg;
            item_reg   <= {item_size, val_ext[VALUE_WIDTH-1:0]};
            out_reg    <= '0;
        end else begin
            unique case (state_reg)
                bpl_pkg::ST_UP_WR:    ptr_reg <= ptr_dec;
                bpl_pkg::ST_TAKE_CAP: begin
                    out_reg <= mem_rdata;
                    ptr_reg <= idx_reg;
                end
                bpl_pkg::ST_DN_WR:    ptr_reg <= ptr_inc;
                default:              ptr_reg <= ptr_reg;
            endcase
        end
    end

    bpl_store #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> hw/rtl/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of up to DEPTH entries (handle and byte size) with insert,
// extract and read at the front, back or a position, plus clear.
// ----------------------------------------------------------------------------
// One command is taken at a time and every command returns one result. The
// entries sit packed in list order in a single-port-read, single-port-write
// memory, so moving an entry takes a read, then a write. With n entries in
// the list, errors, clear and unknown codes go straight to the finish state;
// reads read and capture the entry; insert at index i moves n - i entries
// from index i up one place, then writes the new entry; extract at index i
// reads and captures the entry, then moves the n - i - 1 entries after it
// down one place. The capacity register may be written at any time the list
// is idle and takes effect at once; no clearing pass is needed after reset.
module bounded_positional_list #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: cmd[3:0], item_value[35:4], item_size[51:36], position[55:52]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpl_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: status[2:0], out_value[34:3], out_size[50:35], count_now[55:51],
    //          is_full[56], is_empty[57], zero[63:58]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpl_pkg::M_TDATA_W-1:0]     m_tdata,
    // capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpl_pkg::CFG_W-1:0]         cfg_data
);

    logic                      m_valid_reg;
    logic [bpl_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                      out_free;
    logic                      res_load;
    bpl_pkg::result_t          res;

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    bpl_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (s_tdata[3:0]),
        .item_value (s_tdata[35:4]),
        .item_size  (s_tdata[51:36]),
        .position   (s_tdata[55:52]),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res)
    );

    // output register holds a result until its transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= bpl_pkg::M_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
